[hdl/qsla_pkg.sv]
// shared types and constants for the log sieve accumulator
package qsla_pkg;
	localparam int CHUNK_DEF = 4096;
	localparam int SLOTS_DEF = 1024;
	localparam int LOG_BITS_DEF = 16;
	localparam int IDX_W = 25;
	localparam int PRIME_W = 24;
	localparam int WEIGHT_W = 16;
	localparam int SLOT_W = 10;
	localparam int POS_W = 12;
	localparam int THR_W = 16;

	typedef enum logic [1:0] {
		CMD_INIT = 2'd0,
		CMD_SIEVE = 2'd1,
		CMD_SCAN = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT_A,
		OP_DIV_START,
		OP_INIT_WRITE,
		OP_SLOT_READ,
		OP_SIEVE_LOAD,
		OP_WALK_START,
		OP_WALK_STEP,
		OP_WALK_END,
		OP_SIEVE_WRITE,
		OP_SCAN_READ,
		OP_SCAN_OUT,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t op;
		logic root_sel;
	} cmd_bus_t;

	typedef struct packed {
		logic div_done;
		logic walk_done;
		logic clear_done;
		logic slot_ok;
		logic small_rule;
	} stat_bus_t;
endpackage

[hdl/qsla_ctrl.sv]
// controller state machine for the log sieve accumulator
module qsla_ctrl
	import qsla_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  cmd_t      in_cmd,
	input  logic      out_busy,
	input  stat_bus_t stat,
	output logic      in_ready,
	output cmd_bus_t  cmd
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_INIT_A, S_DIV, S_INIT_W, S_SRD, S_SLOAD, S_WSTART,
		S_WSTEP, S_WEND, S_SWRITE, S_SCAN_RD, S_SCAN_OUT
	} state_t;

	state_t state_q;
	logic root_q;

	assign in_ready = (state_q == S_IDLE) && !out_busy;

	always_comb begin
		cmd.root_sel = root_q;
		unique case (state_q)
			S_CLEAR:    cmd.op = OP_CLEAR;
			S_INIT_A:   cmd.op = OP_INIT_A;
			S_DIV:      cmd.op = OP_DIV_START;
			S_INIT_W:   cmd.op = OP_INIT_WRITE;
			S_SRD:      cmd.op = OP_SLOT_READ;
			S_SLOAD:    cmd.op = OP_SIEVE_LOAD;
			S_WSTART:   cmd.op = OP_WALK_START;
			S_WSTEP:    cmd.op = OP_WALK_STEP;
			S_WEND:     cmd.op = OP_WALK_END;
			S_SWRITE:   cmd.op = OP_SIEVE_WRITE;
			S_SCAN_RD:  cmd.op = OP_SCAN_READ;
			S_SCAN_OUT: cmd.op = OP_SCAN_OUT;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			root_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: if (stat.clear_done) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_fire) begin
						root_q <= 1'b0;
						unique case (in_cmd)
							CMD_INIT:  state_q <= S_INIT_A;
							CMD_SIEVE: state_q <= S_SRD;
							CMD_SCAN:  state_q <= S_SCAN_RD;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_INIT_A: state_q <= stat.slot_ok ? S_DIV : S_IDLE;
				S_DIV: if (stat.div_done) state_q <= S_INIT_W;
				S_INIT_W: state_q <= S_IDLE;
				S_SRD: state_q <= stat.slot_ok ? S_SLOAD : S_IDLE;
				S_SLOAD: state_q <= S_WSTART;
				S_WSTART: state_q <= S_WSTEP;
				S_WSTEP: if (stat.walk_done) state_q <= S_WEND;
				S_WEND: begin
					if (!root_q) begin
						root_q <= 1'b1;
						state_q <= S_WSTART;
					end else begin
						state_q <= S_SWRITE;
					end
				end
				S_SWRITE: state_q <= S_IDLE;
				S_SCAN_RD: state_q <= S_SCAN_OUT;
				S_SCAN_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/qsla_dp.sv]
// datapath: slot tables, log store, remainder unit and walker
module qsla_dp
	import qsla_pkg::*;
#(
	parameter int CHUNK = CHUNK_DEF,
	parameter int SLOTS = SLOTS_DEF,
	parameter int LOG_BITS = LOG_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_bus_t             cmd,
	input  logic                 in_fire,
	input  logic [SLOT_W-1:0]    in_slot,
	input  logic [PRIME_W-1:0]   in_prime,
	input  logic [WEIGHT_W-1:0]  in_weight,
	input  logic                 in_div,
	input  logic [IDX_W-1:0]     in_base,
	input  logic [PRIME_W-1:0]   in_lo,
	input  logic [PRIME_W-1:0]   in_hi,
	input  logic [POS_W-1:0]     in_pos,
	input  logic [THR_W-1:0]     threshold,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [POS_W-1:0]     out_pos,
	output logic [LOG_BITS-1:0]  out_sum,
	output logic                 out_above,
	output stat_bus_t            stat
);
	localparam int CW = $clog2(CHUNK);
	localparam int SW = $clog2(SLOTS);
	localparam int CNT_W = CW + 1;
	localparam int SW_ = 28;
	localparam int AW = ((LOG_BITS > WEIGHT_W) ? LOG_BITS : WEIGHT_W) + 1;
	localparam logic [LOG_BITS-1:0] LOG_MAX = '1;
	localparam logic [SW_-1:0] CHUNK_S = SW_'(CHUNK);

	logic [IDX_W-1:0] i1_mem [SLOTS];
	logic [IDX_W-1:0] i2_mem [SLOTS];
	logic [IDX_W-1:0] st_mem [SLOTS];
	logic [LOG_BITS-1:0] store [CHUNK];

	logic [SLOT_W-1:0] slot_q;
	logic [PRIME_W-1:0] p_q;
	logic [WEIGHT_W-1:0] w_q;
	logic div_q;
	logic [IDX_W-1:0] q_q;
	logic [PRIME_W-1:0] lo_q, hi_q;
	logic [POS_W-1:0] pos_q;

	logic signed [SW_-1:0] i1_q, i2_q;
	logic [IDX_W-1:0] r1_q, r2_q, rst_q;
	logic [IDX_W-1:0] idx_q [2];
	logic [IDX_W-1:0] nidx_q [2];

	logic [LOG_BITS-1:0] rd_q;
	logic [CNT_W-1:0] clr_q;

	// restoring remainder unit, one quotient bit per cycle
	logic div_busy_q, div_done_q;
	logic [SW_-1:0] rem_q;
	logic [SW_-1:0] dvd_q;
	logic [4:0] dcnt_q;
	logic neg_q;

	logic [SW_-1:0] walk_q;
	logic walk_busy_q;

	logic slot_ok;
	assign slot_ok = 32'(slot_q) < 32'(SLOTS);

	assign stat.div_done = div_done_q;
	assign stat.walk_done = !walk_busy_q;
	assign stat.clear_done = clr_q == CNT_W'(CHUNK);
	assign stat.slot_ok = slot_ok;
	assign stat.small_rule = 32'(p_q) < 32'(CHUNK);

	logic signed [SW_-1:0] sp, sq, slo, shi, i1c, i2c, ndiff;
	always_comb begin
		sp = SW_'(p_q);
		sq = SW_'(q_q);
		slo = SW_'(lo_q);
		shi = SW_'(hi_q);
		if (!div_q) begin
			i1c = (slo > sq) ? slo - sq : sp + slo - sq;
			i2c = (shi > sq) ? shi - sq : sp + shi - sq;
		end else begin
			i1c = '0;
			i2c = (sq == slo) ? shi - slo : sp - (shi - slo);
		end
		ndiff = i1_q - $signed(CHUNK_S);
	end

	logic [SW_-1:0] rem_sh, rem_sub;
	logic signed [SW_-1:0] r_s, n_s, st_s;
	always_comb begin
		rem_sh = {rem_q[SW_-2:0], dvd_q[SW_-1]};
		rem_sub = rem_sh - SW_'(p_q);
		r_s = neg_q ? -$signed(rem_q) : $signed(rem_q);
		if (p_q == '0) r_s = '0;
		n_s = r_s + sp;
		st_s = (n_s > i1_q) ? n_s - i1_q : sp - i1_q + n_s;
	end

	// walker current root
	logic [IDX_W-1:0] cur;
	logic [SW_-1:0] adv;
	always_comb begin
		cur = idx_q[cmd.root_sel];
		if (stat.small_rule) begin
			adv = SW_'(cur) + SW_'(rst_q);
			if (adv >= SW_'(p_q)) adv = adv - SW_'(p_q);
		end else if (SW_'(cur) < CHUNK_S) begin
			adv = SW_'(cur) + SW_'(p_q) - CHUNK_S;
		end else begin
			adv = SW_'(cur) - CHUNK_S;
		end
	end

	// read-modify-write of the store; a new hit waits until the previous hit is written back
	logic hit_s1;
	logic [CW-1:0] hpos_s1;
	logic [LOG_BITS-1:0] hsum;
	logic [AW-1:0] hadd;
	logic hit_now;
	logic [SW_-1:0] wstep;
	always_comb begin
		hadd = AW'(rd_q) + AW'(w_q);
		hsum = (hadd > AW'(LOG_MAX)) ? LOG_MAX : hadd[LOG_BITS-1:0];
		hit_now = walk_busy_q && !hit_s1 && walk_q < CHUNK_S;
		wstep = walk_q + SW_'(p_q);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q <= in_slot;
			p_q <= in_prime;
			w_q <= in_weight;
			div_q <= in_div;
			q_q <= in_base;
			lo_q <= in_lo;
			hi_q <= in_hi;
			pos_q <= in_pos;
		end
		if (cmd.op == OP_INIT_A) begin
			i1_q <= i1c;
			i2_q <= i2c;
		end
		if (cmd.op == OP_DIV_START && !div_busy_q && !div_done_q) begin
			neg_q <= ndiff[SW_-1];
			dvd_q <= ndiff[SW_-1] ? -ndiff : ndiff;
			rem_q <= '0;
			dcnt_q <= 5'(SW_);
		end else if (div_busy_q) begin
			rem_q <= (p_q != '0 && rem_sub[SW_-1] == 1'b0) ? rem_sub : rem_sh;
			dvd_q <= {dvd_q[SW_-2:0], 1'b0};
			dcnt_q <= dcnt_q - 5'd1;
		end
		if (cmd.op == OP_INIT_WRITE && slot_ok) begin
			i1_mem[SW'(slot_q)] <= i1_q[IDX_W-1:0];
			i2_mem[SW'(slot_q)] <= i2_q[IDX_W-1:0];
			st_mem[SW'(slot_q)] <= st_s[IDX_W-1:0];
		end
		if (cmd.op == OP_SLOT_READ && slot_ok) begin
			r1_q <= i1_mem[SW'(slot_q)];
			r2_q <= i2_mem[SW'(slot_q)];
			rst_q <= st_mem[SW'(slot_q)];
		end
		if (cmd.op == OP_SIEVE_LOAD) begin
			idx_q[0] <= r1_q;
			idx_q[1] <= r2_q;
		end
		if (cmd.op == OP_WALK_START) begin
			walk_q <= SW_'(cur);
			nidx_q[cmd.root_sel] <= adv[IDX_W-1:0];
		end else if (hit_now) begin
			walk_q <= (stat.small_rule && p_q != '0) ? wstep : {SW_{1'b1}};
		end
		if (cmd.op == OP_SIEVE_WRITE && slot_ok) begin
			i1_mem[SW'(slot_q)] <= nidx_q[0];
			i2_mem[SW'(slot_q)] <= nidx_q[1];
		end
		hpos_s1 <= walk_q[CW-1:0];
		if (cmd.op == OP_SCAN_READ) rd_q <= store[CW'(pos_q)];
		else rd_q <= store[walk_q[CW-1:0]];
		if (cmd.op == OP_CLEAR) store[clr_q[CW-1:0]] <= '0;
		else if (hit_s1) store[hpos_s1] <= hsum;
		else if (cmd.op == OP_SCAN_READ && 32'(pos_q) < 32'(CHUNK))
			store[CW'(pos_q)] <= '0;
		if (cmd.op == OP_SCAN_OUT) begin
			out_pos <= pos_q;
			out_sum <= (32'(pos_q) < 32'(CHUNK)) ? rd_q : '0;
			out_above <= (32'(pos_q) < 32'(CHUNK)) &&
				(32'(rd_q) > 32'(threshold));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			walk_busy_q <= 1'b0;
			hit_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.op == OP_CLEAR) clr_q <= clr_q + CNT_W'(1);
			if (cmd.op == OP_DIV_START && !div_busy_q && !div_done_q)
				div_busy_q <= 1'b1;
			else if (div_busy_q && dcnt_q == 5'd1) begin
				div_busy_q <= 1'b0;
				div_done_q <= 1'b1;
			end else if (div_done_q) div_done_q <= 1'b0;
			if (cmd.op == OP_WALK_START) walk_busy_q <= 1'b1;
			else if (walk_busy_q && !hit_s1 && walk_q >= CHUNK_S)
				walk_busy_q <= 1'b0;
			hit_s1 <= hit_now;
			if (cmd.op == OP_SCAN_OUT) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end
endmodule

[hdl/quadratic_sieve_log_accumulator_unit.sv]
// top level of the log sieve accumulator
// usage:
// - s_axis carries commands: init a prime slot, sieve a slot over the
//   current chunk, or scan one chunk position
// - only a scan makes a transfer on m_axis: position, log sum, flag
// - log_threshold_we/log_threshold_wdata write the candidate threshold
//   while the unit is idle
// - one command is in work at a time; s_axis_tready rises when done
// - init: waits on the bit-serial remainder unit, then writes the slot
// - sieve: walks both roots over the chunk, with a read-modify-write of
//   the store for each hit
// - scan: reads the store position, then registers the result for m_axis
// - after reset the whole log store is cleared before
//   the first command is taken
// - a stalled m_axis holds its result and blocks new commands
module quadratic_sieve_log_accumulator_unit
	import qsla_pkg::*;
#(
	parameter int CHUNK = CHUNK_DEF,
	parameter int SLOTS = SLOTS_DEF,
	parameter int LOG_BITS = LOG_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         log_threshold_we,
	input  logic [15:0]  log_threshold_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd, slot, prime, log_weight, first_value_divisible, start_base,
	// root_low, root_high, position; zero padded
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// scan_position, log_sum, above_threshold; zero padded
	output logic [31:0]  m_axis_tdata
);
	logic [THR_W-1:0] thr_q;
	logic fire;
	cmd_bus_t cmd;
	stat_bus_t stat;
	logic [POS_W-1:0] opos;
	logic [LOG_BITS-1:0] osum;
	logic oab;

	assign fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= '0;
		else if (log_threshold_we) thr_q <= log_threshold_wdata;
	end

	qsla_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire),
		.in_cmd(cmd_t'(s_axis_tdata[1:0])),
		.out_busy(m_axis_tvalid && !m_axis_tready), .stat(stat),
		.in_ready(s_axis_tready), .cmd(cmd)
	);

	qsla_dp #(.CHUNK(CHUNK), .SLOTS(SLOTS), .LOG_BITS(LOG_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_fire(fire),
		.in_slot(s_axis_tdata[11:2]), .in_prime(s_axis_tdata[35:12]),
		.in_weight(s_axis_tdata[51:36]), .in_div(s_axis_tdata[52]),
		.in_base(s_axis_tdata[77:53]), .in_lo(s_axis_tdata[101:78]),
		.in_hi(s_axis_tdata[125:102]), .in_pos(s_axis_tdata[137:126]),
		.threshold(thr_q), .out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid), .out_pos(opos), .out_sum(osum),
		.out_above(oab), .stat(stat)
	);

	assign m_axis_tdata = {3'b000, oab, 16'(osum), opos};
endmodule
